>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the core.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante -> cons");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante => cons");

`endif

>>> rtl/core/hcc_pkg.sv
// Package for the RGB hue color classifier: class codes, thresholds and
// the structs carried between pipeline stages. No dependencies.
package hcc_pkg;

    typedef enum logic [3:0] {
        CLS_BLACK  = 4'd0,
        CLS_WHITE  = 4'd1,
        CLS_GRAY   = 4'd2,
        CLS_RED    = 4'd3,
        CLS_ORANGE = 4'd4,
        CLS_YELLOW = 4'd5,
        CLS_GREEN  = 4'd6,
        CLS_BLUE   = 4'd7,
        CLS_PURPLE = 4'd8
    } hcc_class_t;

    typedef enum logic [1:0] {
        MAX_RED   = 2'd0,
        MAX_GREEN = 2'd1,
        MAX_BLUE  = 2'd2
    } hcc_max_t;

    localparam int HUE_QW   = 9;
    localparam int SAT_QW   = 8;
    localparam int DIV_STEPS = HUE_QW;

    // Sum max+min limits for black (lightness < 0.2) and white (> 0.9)
    localparam logic [8:0] BLACK_SUM_LIM = 9'd102;
    localparam logic [8:0] WHITE_SUM_LIM = 9'd459;

    // Hue band upper bounds in degrees
    localparam logic [8:0] HUE_RED_END    = 9'd20;
    localparam logic [8:0] HUE_ORANGE_END = 9'd45;
    localparam logic [8:0] HUE_YELLOW_END = 9'd70;
    localparam logic [8:0] HUE_GREEN_END  = 9'd155;
    localparam logic [8:0] HUE_BLUE_END   = 9'd260;
    localparam logic [8:0] HUE_PURPLE_END = 9'd335;

    typedef struct packed {
        logic [7:0]        chroma;
        logic [8:0]        sum;
        hcc_max_t          max_sel;
        logic signed [8:0] diff;
    } hcc_front_t;

    typedef struct packed {
        logic [16:0] hue_rem;
        logic [7:0]  chroma;
        logic [8:0]  hue_q;
        logic [15:0] sat_rem;
        logic [7:0]  den;
        logic [7:0]  sat_q;
        logic [7:0]  light;
        hcc_class_t  pre_cls;
        logic        pre_hit;
        logic        zero_chroma;
    } hcc_div_t;

    typedef struct packed {
        logic [7:0] light;
        logic [7:0] sat;
        logic [8:0] hue;
        hcc_class_t cls;
    } hcc_result_t;

endpackage

>>> rtl/core/hcc_front.sv
// Front end of the classifier: max/min and chroma (stage 1), hue
// numerator, saturation dividend and early classes (stage 2). Uses hcc_pkg.
module hcc_front
    import hcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        out_valid,
    input  logic        out_ready,
    output hcc_div_t    out_data
);

    logic       s1_valid_reg, s1_valid_next;
    hcc_front_t s1_reg, s1_next;
    logic       s2_valid_reg, s2_valid_next;
    hcc_div_t   s2_reg, s2_next;
    logic       s1_ready, s2_ready;

    logic [7:0] mx, mn;

    logic signed [18:0] diff_ext, chroma_ext, base, hn_full;
    logic [8:0]  den_hi;
    logic [11:0] chroma_x10;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Stage 1: pick the maximum (red wins ties, then green)
    always_comb
    begin
        s1_next = s1_reg;
        if (red >= green && red >= blue)
        begin
            mx = red;
            s1_next.max_sel = MAX_RED;
            s1_next.diff = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (green >= blue)
        begin
            mx = green;
            s1_next.max_sel = MAX_GREEN;
            s1_next.diff = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            mx = blue;
            s1_next.max_sel = MAX_BLUE;
            s1_next.diff = $signed({1'b0, red}) - $signed({1'b0, green});
        end
        mn = red;
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        s1_next.chroma = mx - mn;
        s1_next.sum    = {1'b0, mx} + {1'b0, mn};
        s1_valid_next  = in_valid;
    end

    // Stage 2: hue numerator in [0, 360*C), denominators, early classes
    always_comb
    begin
        diff_ext   = {{10{s1_reg.diff[8]}}, s1_reg.diff};
        chroma_ext = $signed({11'd0, s1_reg.chroma});
        case (s1_reg.max_sel)
            MAX_RED:   base = s1_reg.diff[8] ? chroma_ext * 19'sd360 : 19'sd0;
            MAX_GREEN: base = chroma_ext * 19'sd120;
            MAX_BLUE:  base = chroma_ext * 19'sd240;
            default:   base = 19'sd0;
        endcase
        hn_full    = diff_ext * 19'sd60 + base;
        den_hi     = 9'd510 - s1_reg.sum;
        chroma_x10 = {4'd0, s1_reg.chroma} * 12'd10;

        s2_next             = s2_reg;
        s2_next.hue_rem     = hn_full[16:0];
        s2_next.chroma      = s1_reg.chroma;
        s2_next.hue_q       = '0;
        s2_next.sat_rem     = {s1_reg.chroma, 8'd0} - {8'd0, s1_reg.chroma};
        s2_next.den         = (s1_reg.sum < 9'd255) ? s1_reg.sum[7:0] : den_hi[7:0];
        s2_next.sat_q       = '0;
        s2_next.light       = s1_reg.sum[8:1];
        s2_next.zero_chroma = (s1_reg.chroma == 8'd0);
        s2_next.pre_hit     = 1'b1;
        if (s1_reg.sum < BLACK_SUM_LIM)
        begin
            s2_next.pre_cls = CLS_BLACK;
        end
        else if (s1_reg.sum > WHITE_SUM_LIM)
        begin
            s2_next.pre_cls = CLS_WHITE;
        end
        else if (s1_reg.chroma == 8'd0 || chroma_x10 < {4'd0, s2_next.den})
        begin
            s2_next.pre_cls = CLS_GRAY;
        end
        else
        begin
            s2_next.pre_cls = CLS_RED;
            s2_next.pre_hit = 1'b0;
        end
        s2_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= s1_valid_next;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s2_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_reg <= s1_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_reg;

endmodule

>>> rtl/core/hcc_div_stage.sv
// One restoring-division step for the hue quotient and, while BIT is below
// SAT_QW, the saturation quotient. Resolves quotient bit BIT of each. Uses hcc_pkg.
module hcc_div_stage
    import hcc_pkg::*;
#(
    parameter int unsigned BIT = 0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  hcc_div_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output hcc_div_t out_data
);

    logic     valid_reg;
    hcc_div_t data_reg, data_next;
    logic [16:0] hue_sub;
    logic        hue_ge;

    assign in_ready = !valid_reg || out_ready;
    assign hue_sub  = 17'(in_data.chroma) << BIT;
    assign hue_ge   = (in_data.hue_rem >= hue_sub);

    if (BIT < SAT_QW)
    begin : g_sat
        logic [15:0] sat_sub;
        logic        sat_ge;
        assign sat_sub = 16'(in_data.den) << BIT;
        assign sat_ge  = (in_data.sat_rem >= sat_sub);

        always_comb
        begin
            data_next = in_data;
            data_next.hue_q[BIT] = hue_ge;
            if (hue_ge)
            begin
                data_next.hue_rem = in_data.hue_rem - hue_sub;
            end
            data_next.sat_q[BIT] = sat_ge;
            if (sat_ge)
            begin
                data_next.sat_rem = in_data.sat_rem - sat_sub;
            end
        end
    end
    else
    begin : g_hue_only
        always_comb
        begin
            data_next = in_data;
            data_next.hue_q[BIT] = hue_ge;
            if (hue_ge)
            begin
                data_next.hue_rem = in_data.hue_rem - hue_sub;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/core/hcc_classify.sv
// Final stage: hue band lookup, zero-chroma cleanup and output register.
// Uses hcc_pkg.
module hcc_classify
    import hcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  hcc_div_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output hcc_result_t out_data
);

    logic        valid_reg;
    hcc_result_t res_reg, res_next;
    hcc_class_t  band;

    assign in_ready = !valid_reg || out_ready;

    // floor(hn/C) < k is the same test as hn < k*C for integer k
    always_comb
    begin
        if (in_data.hue_q < HUE_RED_END)
        begin
            band = CLS_RED;
        end
        else if (in_data.hue_q < HUE_ORANGE_END)
        begin
            band = CLS_ORANGE;
        end
        else if (in_data.hue_q < HUE_YELLOW_END)
        begin
            band = CLS_YELLOW;
        end
        else if (in_data.hue_q < HUE_GREEN_END)
        begin
            band = CLS_GREEN;
        end
        else if (in_data.hue_q < HUE_BLUE_END)
        begin
            band = CLS_BLUE;
        end
        else if (in_data.hue_q < HUE_PURPLE_END)
        begin
            band = CLS_PURPLE;
        end
        else
        begin
            band = CLS_RED;
        end
    end

    always_comb
    begin
        res_next.light = in_data.light;
        res_next.hue   = in_data.zero_chroma ? 9'd0 : in_data.hue_q;
        res_next.sat   = in_data.zero_chroma ? 8'd0 : in_data.sat_q;
        res_next.cls   = in_data.pre_hit ? in_data.pre_cls : band;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = res_reg;

endmodule

>>> rtl/core/rgb_hue_color_classifier_core.sv
// Top level of the RGB hue color classifier; instantiates hcc_front,
// hcc_div_stage and hcc_classify, and uses hcc_pkg.
//
// Takes one 24-bit RGB pixel per transaction and returns one result per
// pixel: HSL hue in whole degrees, saturation and lightness scaled to
// 0..255 (all floored), and a color class (black, white, gray or one of
// six hue bands, red wrapping at 335 degrees). The class is decided
// exactly from the integer ratios, never from the rounded fields. The
// block is a 12-stage pipeline: two front stages (max/min and chroma,
// then hue numerator and denominators), nine restoring-division stages
// that each resolve one hue quotient bit (the lower eight also resolve
// one saturation quotient bit in parallel), and a classify stage that is
// also the output register. It accepts one pixel every clock unless a
// stall on m_tready has filled the pipeline. Each stage holds its own
// valid bit, so an output stall fills bubbles upstream before s_tready
// drops. Nothing is carried from one pixel to the next.
module rgb_hue_color_classifier_core
    import hcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // color_class[3:0], hue_degrees[12:4],
                                   // saturation_level[20:13], lightness_level[28:21],
                                   // zero pad [31:29]
);

    // Pipeline links: index 0 is the front end output, DIV_STEPS the
    // last division step output
    logic        link_valid [0:DIV_STEPS];
    logic        link_ready [0:DIV_STEPS];
    hcc_div_t    link_data  [0:DIV_STEPS];
    hcc_result_t result;

    // Unpack the pixel and compute max/min, numerator and early classes
    hcc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .red       (s_tdata[7:0]),
        .green     (s_tdata[15:8]),
        .blue      (s_tdata[23:16]),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_data  (link_data[0])
    );

    // Resolve quotient bits from the most significant one down
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        hcc_div_stage #(
            .BIT (DIV_STEPS - 1 - i)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_data   (link_data[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_data  (link_data[i+1])
        );
    end

    // Pick the hue band, clean up zero chroma, hold the result
    hcc_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (link_valid[DIV_STEPS]),
        .in_ready  (link_ready[DIV_STEPS]),
        .in_data   (link_data[DIV_STEPS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    assign m_tdata = {3'd0, result.light, result.sat, result.hue, result.cls};

endmodule

>>> rtl/core/hcc_checker.sv
// Port-level checker for rgb_hue_color_classifier_core, bound to the top.
// Depends on hcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hcc_checker
    import hcc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    logic       out_stall;
    logic       class_ok;
    logic [3:0] out_cls;
    logic [8:0] out_hue;
    logic [7:0] out_sat;
    logic [7:0] out_light;
    logic       black_cls;
    logic       early_cls;

    assign out_stall = m_tvalid && !m_tready;
    assign out_cls   = m_tdata[3:0];
    assign out_hue   = m_tdata[12:4];
    assign out_sat   = m_tdata[20:13];
    assign out_light = m_tdata[28:21];
    assign class_ok  = (out_cls <= CLS_PURPLE);
    assign black_cls = (out_cls == CLS_BLACK);
    assign early_cls = black_cls || out_cls == CLS_WHITE || out_cls == CLS_GRAY;

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_tvalid && $stable(m_tdata))
    `ASSERT_IMPLIES(a_class_range, clk, rst_n, m_tvalid, class_ok && out_hue < 9'd360)
    `ASSERT_IMPLIES(a_black_light, clk, rst_n, m_tvalid, (out_light < 8'd51) == black_cls)
    `ASSERT_IMPLIES(a_zero_sat, clk, rst_n, m_tvalid && out_sat == 8'd0, early_cls)

endmodule

bind rgb_hue_color_classifier_core hcc_checker u_hcc_checker (.*);
